// File: rtl/bfs_pkg.sv
// Shared types and constants of the bilinear frame sampler.
// No dependencies; every other file uses this package.
`default_nettype none

package bfs_pkg;

  localparam int CoordBits   = 16;
  localparam int PixInBits   = 16;
  localparam int WeightBits  = 6;
  localparam int CfgDataBits = 9;
  localparam int CfgIdxBits  = 1;

  localparam logic [WeightBits-1:0] WEIGHT_ONE = 6'd32;
  localparam int BLEND_SHIFT = 10;

  localparam logic [CfgDataBits-1:0] FRAME_DIM_RESET = 9'd256;

  localparam logic [CfgIdxBits-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CfgIdxBits-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam int QueueDepth = 4;
  // queue plus read, horizontal and vertical stages
  localparam int PendingMax = QueueDepth + 3;

  typedef enum logic {
    MODE_STORE  = 1'b0,
    MODE_SAMPLE = 1'b1
  } bfs_mode_e;

  typedef struct packed {
    logic                  is_write;
    logic                  interior;
    logic                  par_x;
    logic                  par_y;
    logic [WeightBits-1:0] wx;
    logic [WeightBits-1:0] wy;
    logic [PixInBits-1:0]  pixel;
  } bfs_item_t;

endpackage

`default_nettype wire

// File: rtl/bfs_if.sv
// Valid/ready channel interfaces for input items and results.
// Depends on bfs_pkg for field widths.
`default_nettype none

interface bfs_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [bfs_pkg::CoordBits-1:0]    coord_x;
  logic [bfs_pkg::CoordBits-1:0]    coord_y;
  logic [bfs_pkg::PixInBits-1:0]    pixel_in;
  logic [bfs_pkg::WeightBits-1:0]   weight_x;
  logic [bfs_pkg::WeightBits-1:0]   weight_y;

  modport source (output valid, mode, coord_x, coord_y, pixel_in, weight_x, weight_y,
                  input ready);
  modport sink   (input valid, mode, coord_x, coord_y, pixel_in, weight_x, weight_y,
                  output ready);
endinterface

interface bfs_out_if;
  logic                          valid;
  logic                          ready;
  logic [bfs_pkg::PixInBits-1:0] sample_value;
  logic                          inside_res;

  modport source (output valid, sample_value, inside_res, input ready);
  modport sink   (input valid, sample_value, inside_res, output ready);
endinterface

`default_nettype wire

// File: rtl/bfs_front.sv
// Front end: frame size registers, interior test, weight saturation and bank addressing.
// Depends on bfs_pkg and bfs_if; feeds bfs_queue.
`default_nettype none

module bfs_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int ADDR_W     = 14
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [bfs_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  wire logic [bfs_pkg::CfgDataBits-1:0]    cfg_data_i,
  bfs_in_if.sink                                  in_i,
  output logic                                    push_o,
  output bfs_pkg::bfs_item_t                      item_o,
  output logic [3:0][ADDR_W-1:0]                  addr_o,
  input  wire logic                               q_ready_i
);
  import bfs_pkg::*;

  localparam int BankCols = (MAX_WIDTH + 1) / 2;
  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [CfgDataBits-1:0] width_q, height_q;
  logic [CfgDataBits-1:0] w_eff, h_eff;
  logic                   is_sample;
  logic [CoordBits-1:0]   x_u, y_u;
  logic                   in_x, in_y, wr_ok;
  logic [XW-1:0]          x_low, col1;
  logic [YW-1:0]          y_low, row1;
  logic [XW-1:0]          col [2];
  logic [YW-1:0]          row [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_DIM_RESET;
      height_q <= FRAME_DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = (32'(width_q) > MAX_WIDTH) ? CfgDataBits'(MAX_WIDTH) : width_q;
    h_eff = (32'(height_q) > MAX_HEIGHT) ? CfgDataBits'(MAX_HEIGHT) : height_q;
    is_sample = (in_i.mode == MODE_SAMPLE);
    x_u = {1'b0, in_i.coord_x[CoordBits-2:0]};
    y_u = {1'b0, in_i.coord_y[CoordBits-2:0]};
    in_x = !in_i.coord_x[CoordBits-1] &&
           ((x_u + CoordBits'(1)) < CoordBits'(w_eff));
    in_y = !in_i.coord_y[CoordBits-1] &&
           ((y_u + CoordBits'(1)) < CoordBits'(h_eff));
    wr_ok = !in_i.coord_x[CoordBits-1] && !in_i.coord_y[CoordBits-1] &&
            (x_u < CoordBits'(MAX_WIDTH)) && (y_u < CoordBits'(MAX_HEIGHT));

    x_low = in_i.coord_x[XW-1:0];
    y_low = in_i.coord_y[YW-1:0];
    col1  = x_low >> 1;
    row1  = y_low >> 1;
    col[1] = col1;
    col[0] = col1 + XW'(x_low[0]);
    row[1] = row1;
    row[0] = row1 + YW'(y_low[0]);
    for (int b = 0; b < 4; b++) begin
      addr_o[b] = ADDR_W'(32'(row[b / 2]) * BankCols + 32'(col[b % 2]));
    end

    item_o.is_write = !is_sample;
    item_o.interior = in_x && in_y;
    item_o.par_x    = x_low[0];
    item_o.par_y    = y_low[0];
    item_o.wx       = (in_i.weight_x > WEIGHT_ONE) ? WEIGHT_ONE : in_i.weight_x;
    item_o.wy       = (in_i.weight_y > WEIGHT_ONE) ? WEIGHT_ONE : in_i.weight_y;
    item_o.pixel    = in_i.pixel_in;
  end

  assign in_i.ready = q_ready_i;
  // drop stores that fall outside the frame store
  assign push_o = in_i.valid && q_ready_i && (is_sample || wr_ok);

endmodule

`default_nettype wire

// File: rtl/bfs_queue.sv
// Short FIFO between front and back end.
// Depends on bfs_pkg for its depth.
`default_nettype none

module bfs_queue #(
  parameter int DATA_W = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] data_i,
  output logic                   ready_o,
  output logic                   valid_o,
  output logic [DATA_W-1:0]      data_o,
  input  wire logic              pop_i
);
  import bfs_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  logic [DATA_W-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign ready_o = (count_q != (PtrW+1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// File: rtl/bfs_back.sv
// Back end: four pixel banks split by column and row parity, and the blend pipeline.
// Depends on bfs_pkg and bfs_if; drains bfs_queue.
`default_nettype none

module bfs_back #(
  parameter int PIXEL_BITS = 16,
  parameter int ADDR_W     = 14,
  parameter int BANK_DEPTH = 16384
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_valid_i,
  input  wire bfs_pkg::bfs_item_t          item_i,
  input  wire logic [3:0][ADDR_W-1:0]      addr_i,
  output logic                             pop_o,
  bfs_out_if.source                        out_o
);
  import bfs_pkg::*;

  localparam int TopW = PIXEL_BITS + 5;
  localparam int SumW = PIXEL_BITS + 10;

  logic [PIXEL_BITS-1:0] bank0 [BANK_DEPTH];
  logic [PIXEL_BITS-1:0] bank1 [BANK_DEPTH];
  logic [PIXEL_BITS-1:0] bank2 [BANK_DEPTH];
  logic [PIXEL_BITS-1:0] bank3 [BANK_DEPTH];

  logic                     en;
  logic                     rd_en, wr_en;
  logic [3:0]               wr_sel;
  logic [3:0][PIXEL_BITS-1:0] rd_q;

  logic                     s1_valid_q;
  logic                     s1_inside_q, s1_px_q, s1_py_q;
  logic [WeightBits-1:0]    s1_wx_q, s1_wy_q;

  logic                     s2_valid_q, s2_inside_q;
  logic [WeightBits-1:0]    s2_wy_q;
  logic [TopW-1:0]          top_q, bot_q, top_d, bot_d;

  logic                     s3_valid_q, s3_inside_q;
  logic [PixInBits-1:0]     s3_value_q;
  logic [SumW-1:0]          sum_d;

  logic [PIXEL_BITS-1:0]    pa, pb, pc, pd;
  logic [WeightBits-1:0]    iwx, iwy;
  logic [PIXEL_BITS-1:0]    wr_pix;

  // advance the pipeline unless the result register is held
  assign en     = !s3_valid_q || out_o.ready;
  assign pop_o  = q_valid_i && (item_i.is_write || en);
  assign rd_en  = en && q_valid_i && !item_i.is_write && item_i.interior;
  assign wr_en  = q_valid_i && item_i.is_write;
  assign wr_pix = item_i.pixel[PIXEL_BITS-1:0];

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      wr_sel[b] = wr_en && (2'(b) == {item_i.par_y, item_i.par_x});
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_sel[0]) bank0[addr_i[0]] <= wr_pix;
    if (wr_sel[1]) bank1[addr_i[1]] <= wr_pix;
    if (wr_sel[2]) bank2[addr_i[2]] <= wr_pix;
    if (wr_sel[3]) bank3[addr_i[3]] <= wr_pix;
    if (rd_en) begin
      rd_q[0] <= bank0[addr_i[0]];
      rd_q[1] <= bank1[addr_i[1]];
      rd_q[2] <= bank2[addr_i[2]];
      rd_q[3] <= bank3[addr_i[3]];
    end
  end

  always_comb begin
    pa  = rd_q[{s1_py_q, s1_px_q}];
    pb  = rd_q[{s1_py_q, !s1_px_q}];
    pc  = rd_q[{!s1_py_q, s1_px_q}];
    pd  = rd_q[{!s1_py_q, !s1_px_q}];
    iwx = WEIGHT_ONE - s1_wx_q;
    top_d = TopW'(pa) * TopW'(iwx) + TopW'(pb) * TopW'(s1_wx_q);
    bot_d = TopW'(pc) * TopW'(iwx) + TopW'(pd) * TopW'(s1_wx_q);
    iwy = WEIGHT_ONE - s2_wy_q;
    sum_d = SumW'(top_q) * SumW'(iwy) + SumW'(bot_q) * SumW'(s2_wy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= q_valid_i && !item_i.is_write;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_inside_q <= item_i.interior;
      s1_px_q     <= item_i.par_x;
      s1_py_q     <= item_i.par_y;
      s1_wx_q     <= item_i.wx;
      s1_wy_q     <= item_i.wy;
      s2_inside_q <= s1_inside_q;
      s2_wy_q     <= s1_wy_q;
      top_q       <= top_d;
      bot_q       <= bot_d;
      s3_inside_q <= s2_inside_q;
      s3_value_q  <= s2_inside_q ? PixInBits'(sum_d[SumW-1:BLEND_SHIFT]) : '0;
    end
  end

  assign out_o.valid        = s3_valid_q;
  assign out_o.sample_value = s3_value_q;
  assign out_o.inside_res   = s3_inside_q;

endmodule

`default_nettype wire

// File: rtl/bilinear_frame_sampler.sv
// Top level of the bilinear frame sampler: front end, queue and back end.
// Depends on bfs_pkg, bfs_if, bfs_front, bfs_queue and bfs_back.
//
// The block takes one item per clock, store or sample, while the queue has room, and
// gives one result per sample: the item passes through the queue, the registered read
// of the pixel banks and the horizontal blend, with the vertical blend landing in the
// result register. The frame store is split into four banks by column and row parity,
// so the four neighbours of a sample come from one read port per bank in the same cycle.
// A store commits as it leaves the queue, so a sample taken after it always sees the new
// pixel. The store has no clearing pass; a sample that touches a pixel never written
// since reset returns an undefined value.
`default_nettype none

module bilinear_frame_sampler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bfs_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [bfs_pkg::CfgDataBits-1:0] cfg_data_i,
  bfs_in_if.sink                               in_i,
  bfs_out_if.source                            out_o
);
  import bfs_pkg::*;

  localparam int BankCols  = (MAX_WIDTH + 1) / 2;
  localparam int BankRows  = (MAX_HEIGHT + 1) / 2;
  localparam int BankDepth = BankCols * BankRows;
  localparam int AddrW     = (BankDepth > 1) ? $clog2(BankDepth) : 1;
  localparam int ItemW     = $bits(bfs_item_t);
  localparam int EntryW    = ItemW + 4 * AddrW;

  logic                    push, q_ready, q_valid, pop;
  bfs_item_t               f_item, b_item;
  logic [3:0][AddrW-1:0]   f_addr, b_addr;
  logic [EntryW-1:0]       q_head;

  bfs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ADDR_W     (AddrW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .push_o     (push),
    .item_o     (f_item),
    .addr_o     (f_addr),
    .q_ready_i  (q_ready)
  );

  bfs_queue #(
    .DATA_W (EntryW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_item, f_addr}),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_head),
    .pop_i   (pop)
  );

  assign b_item = q_head[EntryW-1 -: ItemW];
  assign b_addr = q_head[4*AddrW-1:0];

  bfs_back #(
    .PIXEL_BITS (PIXEL_BITS),
    .ADDR_W     (AddrW),
    .BANK_DEPTH (BankDepth)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .item_i    (b_item),
    .addr_i    (b_addr),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

// File: rtl/bfs_checker.sv
// Port-level checks of the bilinear frame sampler, bound to the top level.
// Depends on bfs_pkg.
`default_nettype none

module bfs_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          in_mode,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [bfs_pkg::PixInBits-1:0] sample_value,
  input wire logic                          inside_res
);
  import bfs_pkg::*;

  logic       in_take, out_take;
  logic [3:0] pending_q, pending_d;

  assign in_take   = in_valid && in_ready && (in_mode == MODE_SAMPLE);
  assign out_take  = out_valid && out_ready;
  assign pending_d = pending_q + 4'(in_take) - 4'(out_take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(sample_value) && $stable(inside_res))
    else $error("result changed while stalled");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !inside_res |-> sample_value == '0)
    else $error("outside result carries a nonzero value");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pending_q != '0)
    else $error("result without a pending sample");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pending_q) <= PendingMax)
    else $error("more samples in flight than the pipeline holds");

endmodule

bind bilinear_frame_sampler bfs_checker u_bfs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .in_mode      (in_i.mode),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .sample_value (out_o.sample_value),
  .inside_res   (out_o.inside_res)
);

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for bilinear_frame_sampler: pixel stores, samples and frame registers.
// Keeps its own copy of the frame store to predict each blended sample.
// Depends on bfs_pkg, bfs_if and the RTL of the sampler.
`default_nettype none

module testbench;
  import bfs_pkg::*;

  localparam int FrameCols   = 256;
  localparam int FrameRows   = 256;
  localparam int PixelBits   = 16;
  localparam int DrainCycles = 8;
  localparam int LongHold    = 300;
  localparam int CycleLimit  = 1000000;

  typedef struct packed {
    bfs_mode_e             mode;
    logic [CoordBits-1:0]  coord_x;
    logic [CoordBits-1:0]  coord_y;
    logic [PixInBits-1:0]  pixel;
    logic [WeightBits-1:0] weight_x;
    logic [WeightBits-1:0] weight_y;
  } frame_item_t;

  typedef struct packed {
    logic [PixInBits-1:0] value;
    logic                 interior;
  } blend_res_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  bfs_in_if  item_ch ();
  bfs_out_if res_ch ();

  bilinear_frame_sampler #(
    .MAX_WIDTH (FrameCols),
    .MAX_HEIGHT(FrameRows),
    .PIXEL_BITS(PixelBits)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (item_ch),
    .out_o     (res_ch)
  );

  logic [PixInBits-1:0] frame_mirror [FrameCols*FrameRows];
  bit                   pixel_known  [FrameCols*FrameRows];
  logic [CfgDataBits-1:0] frame_cols;
  logic [CfgDataBits-1:0] frame_rows;
  blend_res_t pending_blends [$];
  int  errors;
  int  cycle_count;
  bit  steady_flow;
  bit  hold_results;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int eff_cols();
    return (frame_cols > FrameCols) ? FrameCols : int'(frame_cols);
  endfunction

  function automatic int eff_rows();
    return (frame_rows > FrameRows) ? FrameRows : int'(frame_rows);
  endfunction

  function automatic bit point_inside(input int x, input int y);
    return x >= 0 && x < eff_cols() - 1 && y >= 0 && y < eff_rows() - 1;
  endfunction

  function automatic int unsigned clamp_weight(input logic [WeightBits-1:0] w);
    return (w > WEIGHT_ONE) ? int'(WEIGHT_ONE) : int'(w);
  endfunction

  function automatic int unsigned pixel_at(input int x, input int y);
    return frame_mirror[y*FrameCols + x];
  endfunction

  // Update the mirror for a store, queue the expected blend for a sample.
  function automatic void track_frame_item(input frame_item_t it);
    int x, y;
    int unsigned wx, wy, top, bot;
    blend_res_t res;
    x = $signed(it.coord_x);
    y = $signed(it.coord_y);
    if (it.mode == MODE_STORE) begin
      if (x >= 0 && x < FrameCols && y >= 0 && y < FrameRows) begin
        frame_mirror[y*FrameCols + x] = it.pixel;
        pixel_known[y*FrameCols + x]  = 1'b1;
      end
    end else begin
      res = '0;
      if (point_inside(x, y)) begin
        wx  = clamp_weight(it.weight_x);
        wy  = clamp_weight(it.weight_y);
        top = pixel_at(x, y) * (WEIGHT_ONE - wx) + pixel_at(x + 1, y) * wx;
        bot = pixel_at(x, y + 1) * (WEIGHT_ONE - wx) + pixel_at(x + 1, y + 1) * wx;
        res.value    = PixInBits'((top * (WEIGHT_ONE - wy) + bot * wy) >> BLEND_SHIFT);
        res.interior = 1'b1;
      end
      pending_blends.push_back(res);
    end
  endfunction

  always @(posedge clk_i) begin
    blend_res_t want;
    if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_blends.size() == 0) begin
        $error("unexpected result: sample_value %0h inside_res %0b",
               res_ch.sample_value, res_ch.inside_res);
        errors++;
      end else begin
        want = pending_blends.pop_front();
        if (res_ch.sample_value !== want.value) begin
          $error("sample_value: expected %0h, got %0h", want.value, res_ch.sample_value);
          errors++;
        end
        if (res_ch.inside_res !== want.interior) begin
          $error("inside_res: expected %0b, got %0b", want.interior, res_ch.inside_res);
          errors++;
        end
      end
    end
  end

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int stall_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        hold_results = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        res_ch.ready <= 1'b1;
      end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
        stall = stall_len();
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  function automatic frame_item_t make_item(input bfs_mode_e mode, input int x, input int y,
                                            input logic [PixInBits-1:0] pixel,
                                            input logic [WeightBits-1:0] wx,
                                            input logic [WeightBits-1:0] wy);
    frame_item_t it;
    it.mode     = mode;
    it.coord_x  = CoordBits'(x);
    it.coord_y  = CoordBits'(y);
    it.pixel    = pixel;
    it.weight_x = wx;
    it.weight_y = wy;
    return it;
  endfunction

  // Leave valid high across back-to-back transfers.
  task automatic send_item(input frame_item_t it);
    int gap;
    gap = steady_flow ? 0 : sender_gap();
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_ch.valid    <= 1'b1;
    item_ch.mode     <= it.mode;
    item_ch.coord_x  <= it.coord_x;
    item_ch.coord_y  <= it.coord_y;
    item_ch.pixel_in <= it.pixel;
    item_ch.weight_x <= it.weight_x;
    item_ch.weight_y <= it.weight_y;
    do @(posedge clk_i); while (item_ch.ready !== 1'b1);
    track_frame_item(it);
  endtask

  function automatic logic [PixInBits-1:0] pick_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return PixInBits'($urandom);
  endfunction

  function automatic logic [WeightBits-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return WEIGHT_ONE;
    if (r < 85) return WeightBits'($urandom_range(0, 32));
    return WeightBits'($urandom_range(33, 63));
  endfunction

  function automatic int wide_coord();
    logic signed [CoordBits-1:0] v;
    v = CoordBits'($urandom);
    return v;
  endfunction

  function automatic int pick_coord(input int dim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, ((dim < 24) ? dim : 24) + 1);
    if (r < 90) return dim - int'($urandom_range(0, 3));
    if (r < 95) return -int'($urandom_range(1, 3));
    return wide_coord();
  endfunction

  function automatic logic [CfgDataBits-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return CfgDataBits'($urandom_range(2, 24));
    if (r < 75) return CfgDataBits'(FrameCols);
    if (r < 85) return CfgDataBits'($urandom_range(257, 511));
    if (r < 92) return CfgDataBits'($urandom_range(0, 1));
    return CfgDataBits'($urandom_range(25, 255));
  endfunction

  // Write any missing neighbor before an interior sample so no unwritten pixel is read.
  task automatic sample_at(input int x, input int y, input logic [WeightBits-1:0] wx,
                           input logic [WeightBits-1:0] wy);
    int dx, dy;
    if (point_inside(x, y)) begin
      for (dy = 0; dy < 2; dy++) begin
        for (dx = 0; dx < 2; dx++) begin
          if (!pixel_known[(y + dy)*FrameCols + x + dx])
            send_item(make_item(MODE_STORE, x + dx, y + dy, pick_pixel(), '0, '0));
        end
      end
    end
    send_item(make_item(MODE_SAMPLE, x, y, pick_pixel(), wx, wy));
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    while (pending_blends.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_frame_dims(input logic [CfgDataBits-1:0] cols,
                                input logic [CfgDataBits-1:0] rows);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FRAME_WIDTH;
    cfg_data_i <= cols;
    @(posedge clk_i);
    frame_cols = cols;
    cfg_idx_i  <= CFG_FRAME_HEIGHT;
    cfg_data_i <= rows;
    @(posedge clk_i);
    frame_rows = rows;
    cfg_we_i   <= 1'b0;
  endtask

  task automatic test_corner_pixels();
    send_item(make_item(MODE_STORE, 0, 0, 16'hFFFF, '0, '0));
    send_item(make_item(MODE_STORE, 1, 0, 16'h0000, '0, '0));
    send_item(make_item(MODE_STORE, 0, 1, 16'h8000, '0, '0));
    send_item(make_item(MODE_STORE, 1, 1, 16'h0001, '0, '0));
    send_item(make_item(MODE_STORE, 254, 254, 16'hFFFF, '0, '0));
    send_item(make_item(MODE_STORE, 255, 254, 16'hFFFF, '0, '0));
    send_item(make_item(MODE_STORE, 254, 255, 16'hFFFF, '0, '0));
    send_item(make_item(MODE_STORE, 255, 255, 16'hFFFF, '0, '0));
    // drop stores outside the frame, including ones that alias pixel (0,0)
    send_item(make_item(MODE_STORE, 256, 0, 16'h1234, '0, '0));
    send_item(make_item(MODE_STORE, 0, 256, 16'h1234, '0, '0));
    send_item(make_item(MODE_STORE, -256, 0, 16'h1234, '0, '0));
    send_item(make_item(MODE_STORE, -32768, -32768, 16'h1234, '0, '0));
    sample_at(0, 0, 0, 0);
    sample_at(0, 0, 32, 0);
    sample_at(0, 0, 0, 32);
    sample_at(0, 0, 32, 32);
    sample_at(0, 0, 16, 16);
    sample_at(0, 0, 63, 33);
    sample_at(254, 254, 31, 31);
    sample_at(254, 254, 32, 32);
    sample_at(255, 0, 5, 5);
    sample_at(0, 255, 5, 5);
    sample_at(-1, 0, 5, 5);
    sample_at(0, -1, 5, 5);
    sample_at(-32768, 32767, 63, 63);
  endtask

  task automatic test_frame_dims();
    int k;
    int dims [6][2] = '{'{2, 2}, '{1, 1}, '{0, 0}, '{511, 511}, '{257, 3}, '{3, 257}};
    for (k = 0; k < 6; k++) begin
      settle();
      set_frame_dims(CfgDataBits'(dims[k][0]), CfgDataBits'(dims[k][1]));
      sample_at(0, 0, 16, 16);
      sample_at(1, 0, 32, 0);
      sample_at(0, 1, 0, 32);
      sample_at(eff_cols() - 2, eff_rows() - 2, 8, 24);
      sample_at(eff_cols() - 1, eff_rows() - 2, 8, 24);
      sample_at(254, 254, 1, 31);
    end
  endtask

  task automatic test_output_hold();
    int n;
    settle();
    set_frame_dims(9'd16, 9'd16);
    steady_flow  = 1'b1;
    hold_results = 1'b1;
    for (n = 0; n < 48; n++)
      sample_at($urandom_range(0, 15), $urandom_range(0, 15), pick_weight(), pick_weight());
    steady_flow = 1'b0;
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      send_item(make_item(MODE_STORE, pick_coord(eff_cols()), pick_coord(eff_rows()),
                          pick_pixel(), pick_weight(), pick_weight()));
    end else if (r < 90) begin
      sample_at(pick_coord(eff_cols()), pick_coord(eff_rows()), pick_weight(), pick_weight());
    end else if ($urandom_range(0, 1) == 0) begin
      send_item(make_item(MODE_STORE, wide_coord(), wide_coord(), pick_pixel(),
                          WeightBits'($urandom), WeightBits'($urandom)));
    end else begin
      sample_at(wide_coord(), wide_coord(), WeightBits'($urandom), WeightBits'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int phase, n;
    for (phase = 0; phase < 6; phase++) begin
      settle();
      set_frame_dims(pick_dim(), pick_dim());
      for (n = 0; n < 220; n++) begin
        if (n % 64 == 0)
          steady_flow = ($urandom_range(0, 3) == 0);
        random_item();
      end
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_FRAME_WIDTH;
    cfg_data_i       = '0;
    item_ch.valid    = 1'b0;
    item_ch.mode     = MODE_STORE;
    item_ch.coord_x  = '0;
    item_ch.coord_y  = '0;
    item_ch.pixel_in = '0;
    item_ch.weight_x = '0;
    item_ch.weight_y = '0;
    frame_cols       = FRAME_DIM_RESET;
    frame_rows       = FRAME_DIM_RESET;
    errors           = 0;
    cycle_count      = 0;
    steady_flow      = 1'b0;
    hold_results     = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_pixels();
    test_frame_dims();
    test_output_hold();
    test_random_traffic();
    settle();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
